@@ hw/rtl/forest_component_labeler_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Forest component labeler assertion macros
// Shared property templates for the checker of the labeler unit.
// ----------------------------------------------------------------------------
`ifndef FOREST_COMPONENT_LABELER_UNIT_DEFINES_SVH
`define FOREST_COMPONENT_LABELER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FCL_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fcl assertion failed");

// Next-cycle implication, disabled while reset is high.
`define FCL_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fcl assertion failed");

// Next-cycle implication that also holds through reset.
`define FCL_ASSERT_RESET(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("fcl reset assertion failed");

`endif

@@ hw/rtl/fcl_pkg.sv @@
// ----------------------------------------------------------------------------
// Forest component labeler package
// Sizes, action codes, state encoding and the node entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package fcl_pkg;

  localparam int MAX_NODES = 1024;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = NODE_W + 1;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_RUN  = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_START,
    S_STEP,
    S_RELAB,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] label;
    logic [CNT_W-1:0] size;
  } node_entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/fcl_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/forest_component_labeler_unit.sv @@
// Loads give no result; a read result passes from the RAM read register to the output
// registers. Loads and reads can be accepted on every cycle unless a read result is held
// back by out_stall. A run clears the labels of all MAX_NODES entries, then per node in
// use takes a start step, a step per node read on its walk and a step per node read when
// relabeling. Input stalls for the whole run; the result comes from the done state.
// Synchronous reset clears control state; labels and sizes read as zero until the first run.
// ----------------------------------------------------------------------------
// Forest component labeler unit
// Labels the components of a parent-pointer forest held in block memory.
// ----------------------------------------------------------------------------
`default_nettype none

module forest_component_labeler_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [fcl_pkg::CNT_W-1:0] cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                action,
  input  wire logic [9:0]                node,
  input  wire logic [9:0]                parent,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic      [10:0]               label,
  output logic      [10:0]               component_size,
  output logic      [10:0]               component_count
);

  fcl_pkg::state_t state, state_next;

  logic [fcl_pkg::CNT_W-1:0]  node_count;
  logic [fcl_pkg::CNT_W-1:0]  count_reg;
  logic                       labeled;
  logic [fcl_pkg::CNT_W-1:0]  n_eff, n_eff_next;
  logic [fcl_pkg::CNT_W-1:0]  next_label, next_label_next;
  logic [fcl_pkg::CNT_W-1:0]  start, start_next;
  logic [fcl_pkg::NODE_W-1:0] cur, cur_next;
  logic [fcl_pkg::CNT_W-1:0]  len, len_next;
  logic [fcl_pkg::CNT_W-1:0]  end_label, end_label_next;
  logic [fcl_pkg::NODE_W-1:0] clr, clr_next;
  logic                       rd_pend;
  logic                       fwd_hit;
  fcl_pkg::node_entry_t       fwd_data;

  logic                       in_accept;
  logic                       out_free;
  logic                       nm_we, nm_re, pm_we, pm_re;
  logic [fcl_pkg::NODE_W-1:0] nm_waddr, rd_addr;
  fcl_pkg::node_entry_t       nm_wdata, nm_rdata, entry;
  logic [fcl_pkg::NODE_W-1:0] pm_rdata, p_next;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != fcl_pkg::S_IDLE) || (rd_pend && !out_free);
  assign entry     = fwd_hit ? fwd_data : nm_rdata;
  assign p_next    = ({1'b0, pm_rdata} < n_eff) ? pm_rdata : cur;
  assign pm_we     = in_accept && (action == fcl_pkg::ACT_LOAD);

  fcl_ram #(
    .WIDTH($bits(fcl_pkg::node_entry_t)),
    .DEPTH(fcl_pkg::MAX_NODES)
  ) u_node_ram (
    .clk  (clk),
    .we   (nm_we),
    .waddr(nm_waddr),
    .wdata(nm_wdata),
    .re   (nm_re),
    .raddr(rd_addr),
    .rdata(nm_rdata)
  );

  fcl_ram #(
    .WIDTH(fcl_pkg::NODE_W),
    .DEPTH(fcl_pkg::MAX_NODES)
  ) u_parent_ram (
    .clk  (clk),
    .we   (pm_we),
    .waddr(node),
    .wdata(parent),
    .re   (pm_re),
    .raddr(rd_addr),
    .rdata(pm_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      fcl_pkg::S_IDLE: begin
        if (in_accept && (action == fcl_pkg::ACT_RUN)) begin
          state_next = fcl_pkg::S_CLEAR;
        end
      end
      fcl_pkg::S_CLEAR: begin
        if (clr == fcl_pkg::NODE_W'(fcl_pkg::MAX_NODES - 1)) begin
          state_next = fcl_pkg::S_START;
        end
      end
      fcl_pkg::S_START: begin
        state_next = (start < n_eff) ? fcl_pkg::S_STEP : fcl_pkg::S_DONE;
      end
      fcl_pkg::S_STEP: begin
        if (entry.label == '0) begin
          state_next = fcl_pkg::S_STEP;
        end else if (len == '0 || entry.label == next_label) begin
          state_next = fcl_pkg::S_START;
        end else begin
          state_next = fcl_pkg::S_RELAB;
        end
      end
      fcl_pkg::S_RELAB: begin
        if (entry.label != next_label) begin
          state_next = fcl_pkg::S_START;
        end
      end
      fcl_pkg::S_DONE: begin
        if (out_free) begin
          state_next = fcl_pkg::S_IDLE;
        end
      end
      default: state_next = fcl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    nm_we           = 1'b0;
    nm_waddr        = cur;
    nm_wdata        = entry;
    nm_re           = 1'b0;
    pm_re           = 1'b0;
    rd_addr         = cur;
    n_eff_next      = n_eff;
    next_label_next = next_label;
    start_next      = start;
    cur_next        = cur;
    len_next        = len;
    end_label_next  = end_label;
    clr_next        = clr;
    unique case (state)
      fcl_pkg::S_IDLE: begin
        rd_addr = node;
        nm_re   = in_accept && (action == fcl_pkg::ACT_READ);
        if (in_accept && (action == fcl_pkg::ACT_RUN)) begin
          n_eff_next      = (node_count > fcl_pkg::CNT_W'(fcl_pkg::MAX_NODES)) ?
                            fcl_pkg::CNT_W'(fcl_pkg::MAX_NODES) : node_count;
          next_label_next = fcl_pkg::CNT_W'(1);
          start_next      = '0;
          clr_next        = '0;
        end
      end
      fcl_pkg::S_CLEAR: begin
        nm_we    = 1'b1;
        nm_waddr = clr;
        nm_wdata = '0;
        clr_next = clr + 1'b1;
      end
      fcl_pkg::S_START: begin
        rd_addr = start[fcl_pkg::NODE_W-1:0];
        if (start < n_eff) begin
          nm_re    = 1'b1;
          pm_re    = 1'b1;
          cur_next = start[fcl_pkg::NODE_W-1:0];
          len_next = '0;
        end
      end
      fcl_pkg::S_STEP: begin
        if (entry.label == '0) begin
          nm_we          = 1'b1;
          nm_wdata.label = next_label;
          len_next       = len + 1'b1;
          cur_next       = p_next;
          rd_addr        = p_next;
          nm_re          = 1'b1;
          pm_re          = 1'b1;
        end else if (len == '0) begin
          start_next = start + 1'b1;
        end else begin
          nm_we         = 1'b1;
          nm_wdata.size = entry.size + len;
          if (entry.label == next_label) begin
            next_label_next = next_label + 1'b1;
            start_next      = start + 1'b1;
          end else begin
            end_label_next = entry.label;
            cur_next       = start[fcl_pkg::NODE_W-1:0];
            rd_addr        = start[fcl_pkg::NODE_W-1:0];
            nm_re          = 1'b1;
            pm_re          = 1'b1;
          end
        end
      end
      fcl_pkg::S_RELAB: begin
        if (entry.label == next_label) begin
          nm_we          = 1'b1;
          nm_wdata.label = end_label;
          cur_next       = p_next;
          rd_addr        = p_next;
          nm_re          = 1'b1;
          pm_re          = 1'b1;
        end else begin
          start_next = start + 1'b1;
        end
      end
      fcl_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fcl_pkg::S_IDLE;
      node_count <= fcl_pkg::CNT_W'(fcl_pkg::MAX_NODES);
      count_reg  <= '0;
      labeled    <= 1'b0;
      next_label <= fcl_pkg::CNT_W'(1);
      rd_pend    <= 1'b0;
      fwd_hit    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      next_label <= next_label_next;
      if (cfg_write) begin
        node_count <= cfg_data;
      end
      if (nm_re) begin
        fwd_hit <= nm_we && (nm_waddr == rd_addr);
      end
      if (in_accept && (action == fcl_pkg::ACT_READ)) begin
        rd_pend <= 1'b1;
      end else if (out_free) begin
        rd_pend <= 1'b0;
      end
      if (state == fcl_pkg::S_DONE && out_free) begin
        count_reg <= next_label - 1'b1;
        labeled   <= 1'b1;
        out_valid <= 1'b1;
      end else if (rd_pend && out_free) begin
        out_valid <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_eff     <= n_eff_next;
    start     <= start_next;
    cur       <= cur_next;
    len       <= len_next;
    end_label <= end_label_next;
    clr       <= clr_next;
    if (nm_re) begin
      fwd_data <= nm_wdata;
    end
    if (state == fcl_pkg::S_DONE && out_free) begin
      label           <= '0;
      component_size  <= '0;
      component_count <= next_label - 1'b1;
    end else if (rd_pend && out_free) begin
      label           <= labeled ? entry.label : '0;
      component_size  <= labeled ? entry.size : '0;
      component_count <= count_reg;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/fcl_checker.sv @@
// ----------------------------------------------------------------------------
// Forest component labeler checker
// Port-level properties of the labeler unit, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "forest_component_labeler_unit_defines.svh"

module fcl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_write,
  input wire logic [10:0] cfg_data,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  action,
  input wire logic [9:0]  node,
  input wire logic [9:0]  parent,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [10:0] label,
  input wire logic [10:0] component_size,
  input wire logic [10:0] component_count
);

  // A held transaction on the result side keeps its payload.
`FCL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(label) && $stable(component_size) && $stable(component_count))

  // Reset leaves no result pending.
`FCL_ASSERT_RESET(a_reset_empty, rst, !out_valid)

  // A nonzero size only sits on a labeled node.
`FCL_ASSERT_SAME(a_size_labeled, out_valid && (component_size != 11'd0), label != 11'd0)

  // No label exceeds the number of components of the last run.
`FCL_ASSERT_SAME(a_label_range, out_valid, label <= component_count)

endmodule

bind forest_component_labeler_unit fcl_checker u_fcl_checker (.*);

`default_nettype wire

@@ bench/forest_labeler_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Forest labeler checker
// Watches both channels and the configuration port of the labeler unit. It
// keeps its own copy of the forest, predicts the result of every accepted run
// and read, and compares the results in order of arrival.
// ----------------------------------------------------------------------------

module forest_labeler_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  action,
  input  logic [9:0]  node,
  input  logic [9:0]  parent,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [10:0] label,
  input  logic [10:0] component_size,
  input  logic [10:0] component_count,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic [10:0] node_lbl;
    logic [10:0] node_size;
    logic [10:0] comp_total;
  } node_report_t;

  logic [9:0]   parent_of [fcl_pkg::MAX_NODES];
  logic [10:0]  lbl_of [fcl_pkg::MAX_NODES];
  logic [10:0]  size_of [fcl_pkg::MAX_NODES];
  int unsigned  walk_path [fcl_pkg::MAX_NODES];
  logic [10:0]  nodes_in_use;
  logic [10:0]  comp_total;
  node_report_t awaited_reports [$];

  function automatic void wipe_results();
    for (int i = 0; i < fcl_pkg::MAX_NODES; i++) begin
      lbl_of[i] = '0;
      size_of[i] = '0;
    end
  endfunction

  function automatic void label_forest();
    int unsigned span;
    int unsigned cur;
    int unsigned len;
    logic [10:0] fresh;
    span = (nodes_in_use > fcl_pkg::MAX_NODES) ? fcl_pkg::MAX_NODES : nodes_in_use;
    wipe_results();
    fresh = 11'd1;
    for (int unsigned start = 0; start < span; start++) begin
      if (lbl_of[start] == '0) begin
        len = 0;
        cur = start;
        while (lbl_of[cur] == '0) begin
          lbl_of[cur] = fresh;
          walk_path[len] = cur;
          len++;
          cur = (parent_of[cur] < span) ? parent_of[cur] : cur;
        end
        if (lbl_of[cur] != fresh) begin
          for (int unsigned i = 0; i < len; i++)
            lbl_of[walk_path[i]] = lbl_of[cur];
        end else begin
          fresh++;
        end
        size_of[cur] = size_of[cur] + 11'(len);
      end
    end
    comp_total = fresh - 11'd1;
  endfunction

  function automatic void check_field(string name, logic [10:0] want, logic [10:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    node_report_t want;
    if (rst) begin
      nodes_in_use = 11'(fcl_pkg::MAX_NODES);
      comp_total = '0;
      wipe_results();
      awaited_reports.delete();
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_reports.size() == 0) begin
          $error("unexpected result: label %0d, size %0d, count %0d",
                 label, component_size, component_count);
          mismatches++;
        end else begin
          want = awaited_reports.pop_front();
          check_field("label", want.node_lbl, label);
          check_field("component_size", want.node_size, component_size);
          check_field("component_count", want.comp_total, component_count);
        end
      end
      if (in_valid && !in_stall) begin
        case (action)
          fcl_pkg::ACT_LOAD: parent_of[node] = parent;
          fcl_pkg::ACT_RUN: begin
            label_forest();
            awaited_reports.push_back('{11'd0, 11'd0, comp_total});
          end
          fcl_pkg::ACT_READ:
            awaited_reports.push_back('{lbl_of[node], size_of[node], comp_total});
          default: ;
        endcase
      end
      if (cfg_write)
        nodes_in_use = cfg_data;
    end
    pending <= awaited_reports.size();
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Forest labeler testbench
// Builds parent-pointer forests of many sizes, runs the labeling and reads
// back labels and sizes under random idling on both channels, including one
// long output hold-off. A checker module predicts and compares every result.
// ----------------------------------------------------------------------------

module tb;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 1500;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [10:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = fcl_pkg::ACT_LOAD;
  logic [9:0]  node = '0;
  logic [9:0]  parent = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [10:0] label;
  logic [10:0] component_size;
  logic [10:0] component_count;

  int chk_fails;
  int chk_pending;
  int cycles = 0;
  bit no_gaps = 1'b0;
  int hold_asks = 0;
  int holds_done = 0;
  bit written [fcl_pkg::MAX_NODES];

  forest_component_labeler_unit u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .node            (node),
    .parent          (parent),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .label           (label),
    .component_size  (component_size),
    .component_count (component_count)
  );

  forest_labeler_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .node            (node),
    .parent          (parent),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .label           (label),
    .component_size  (component_size),
    .component_count (component_count),
    .mismatches      (chk_fails),
    .pending         (chk_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold-off when the stimulus asks.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_asks != holds_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        out_stall <= !no_gaps && ($urandom_range(99) < 34);
      end
    end
  end

  task automatic send(input logic [1:0] act, input int unsigned nd, input int unsigned par);
    while (!no_gaps && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    node <= nd[9:0];
    parent <= par[9:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic load(input int unsigned nd, input int unsigned par);
    send(fcl_pkg::ACT_LOAD, nd, par);
    written[nd[9:0]] = 1'b1;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (chk_pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_node_count(input int unsigned value);
    cfg_write <= 1'b1;
    cfg_data <= value[10:0];
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic int unsigned pick_parent(int unsigned idx, int unsigned span);
    int unsigned r;
    r = $urandom_range(99);
    if (span == 0 || (r >= 85 && r < 95))
      return $urandom_range(1023);
    if (r < 45)
      return $urandom_range((idx < span) ? idx : span - 1);
    if (r < 85)
      return $urandom_range(span - 1);
    return idx;
  endfunction

  task automatic run_phase(input int unsigned count_cfg, input int unsigned items,
                           input bit steady, input bit squeeze);
    int unsigned span;
    int unsigned r;
    int unsigned nd;
    drain();
    set_node_count(count_cfg);
    span = (count_cfg > fcl_pkg::MAX_NODES) ? fcl_pkg::MAX_NODES : count_cfg;
    no_gaps = steady;
    for (int unsigned k = 0; k < span; k++)
      if (!written[k]) load(k, pick_parent(k, span));
    for (int unsigned k = 0; k < items; k++) begin
      r = $urandom_range(99);
      nd = (span > 0 && $urandom_range(9) < 8) ? $urandom_range(span - 1)
                                               : $urandom_range(1023);
      if (r < 40)
        load(nd, pick_parent(nd, span));
      else if (r < 86)
        send(fcl_pkg::ACT_READ, nd, $urandom_range(1023));
      else if (r < 93)
        send(fcl_pkg::ACT_RUN, $urandom_range(1023), $urandom_range(1023));
      else
        send(ACT_UNUSED, $urandom_range(1023), $urandom_range(1023));
    end
    if (squeeze) begin
      send(fcl_pkg::ACT_RUN, 0, 0);
      hold_asks++;
      for (int k = 0; k < 60; k++)
        send(fcl_pkg::ACT_READ, (span > 0) ? $urandom_range(span - 1) : 0, 0);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(fcl_pkg::ACT_READ, 0, 0);
    send(fcl_pkg::ACT_READ, 1023, 1023);
    send(ACT_UNUSED, 1023, 1023);
    drain();
    set_node_count(0);
    send(fcl_pkg::ACT_RUN, 0, 0);
    send(fcl_pkg::ACT_READ, 0, 0);
    drain();
    set_node_count(1);
    load(0, 1023);
    send(fcl_pkg::ACT_RUN, 0, 0);
    send(fcl_pkg::ACT_READ, 0, 0);
    send(fcl_pkg::ACT_READ, 1023, 0);
    drain();
    set_node_count(4);
    load(1, 0);
    load(2, 3);
    load(3, 2);
    load(1023, 0);
    send(fcl_pkg::ACT_RUN, 0, 0);
    for (int k = 0; k < 5; k++)
      send(fcl_pkg::ACT_READ, k, 0);

    run_phase(3, 80, 1'b0, 1'b0);
    run_phase(17, 120, 1'b0, 1'b1);
    run_phase(64, 120, 1'b1, 1'b0);
    run_phase(300, 80, 1'b0, 1'b0);
    run_phase(2047, 60, 1'b0, 1'b0);
    run_phase(1024, 60, 1'b0, 1'b0);
    run_phase(1023, 50, 1'b0, 1'b0);
    run_phase(1, 40, 1'b0, 1'b0);
    run_phase(2, 60, 1'b0, 1'b0);
    run_phase(8, 100, 1'b0, 1'b0);
    run_phase(511, 50, 1'b0, 1'b0);
    run_phase(0, 20, 1'b0, 1'b0);

    drain();
    repeat (20) @(posedge clk);
    if (chk_fails == 0 && chk_pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
